// ===== sv/ctpf_pkg.sv =====
// Shared types, constants and codes of the colour transform and predict filter.
package ctpf_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int MAX_LANES = 8;
   localparam int LANE_W    = 8;
   localparam int PIX_W     = MAX_LANES * LANE_W;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 13;
   localparam int HEIGHT_W  = 16;
   localparam int LANES_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [LANE_W-1:0] LANE_MAX = 8'd255;

   typedef enum logic [2:0] {
      MODE_LEFT     = 3'd0,
      MODE_UP       = 3'd1,
      MODE_AVERAGE  = 3'd2,
      MODE_PAETH    = 3'd3,
      MODE_MED      = 3'd4,
      MODE_GRADIENT = 3'd5
   } pred_mode_type;

   typedef enum logic [1:0] {
      COLOUR_NONE      = 2'd0,
      COLOUR_SUB_GREEN = 2'd1,
      COLOUR_YCOCG     = 2'd2
   } colour_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREDICTOR_MODE  = 3'd0,
      CSR_COLOUR_MODE     = 3'd1,
      CSR_IMAGE_WIDTH     = 3'd2,
      CSR_IMAGE_HEIGHT    = 3'd3,
      CSR_LANES_PER_PIXEL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic [7:0] byte_4;
      logic [7:0] byte_5;
      logic [7:0] byte_6;
      logic [7:0] byte_7;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] residual_0;
      logic [7:0] residual_1;
      logic [7:0] residual_2;
      logic [7:0] residual_3;
      logic [7:0] residual_4;
      logic [7:0] residual_5;
      logic [7:0] residual_6;
      logic [7:0] residual_7;
      logic       row_end;
      logic       image_end;
   } rsp_payload_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } ls_wr_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } ls_rd_type;

endpackage

// ===== sv/ctpf_colour.sv =====
// Colour transform of lanes 0-2: none, green differences (B, G-B, G-R) or YCoCg-R.
module ctpf_colour (
   input  logic [1:0]                  colour_mode,
   input  logic                        active,
   input  logic [ctpf_pkg::LANE_W-1:0] r_in,
   input  logic [ctpf_pkg::LANE_W-1:0] g_in,
   input  logic [ctpf_pkg::LANE_W-1:0] b_in,
   output logic [ctpf_pkg::LANE_W-1:0] c0_out,
   output logic [ctpf_pkg::LANE_W-1:0] c1_out,
   output logic [ctpf_pkg::LANE_W-1:0] c2_out
);

   logic [ctpf_pkg::LANE_W-1:0] co;
   logic [ctpf_pkg::LANE_W-1:0] t;
   logic [ctpf_pkg::LANE_W-1:0] cg;
   logic [ctpf_pkg::LANE_W-1:0] y;

   assign co = r_in - b_in;
   assign t  = b_in + (co >> 1);
   assign cg = g_in - t;
   assign y  = t + (cg >> 1);

   always_comb begin
      c0_out = r_in;
      c1_out = g_in;
      c2_out = b_in;
      if (active) begin
         unique case (ctpf_pkg::colour_mode_type'(colour_mode))
            ctpf_pkg::COLOUR_SUB_GREEN: begin
               c0_out = b_in;
               c1_out = g_in - b_in;
               c2_out = g_in - r_in;
            end
            ctpf_pkg::COLOUR_YCOCG: begin
               c0_out = y;
               c1_out = co;
               c2_out = cg;
            end
            default: begin
               c0_out = r_in;
               c1_out = g_in;
               c2_out = b_in;
            end
         endcase
      end
   end

endmodule

// ===== sv/ctpf_lane.sv =====
// One prediction lane: predict from left, above and above-left, form the residual.
module ctpf_lane (
   input  logic [2:0]                  pred_mode,
   input  logic                        en,
   input  logic [ctpf_pkg::LANE_W-1:0] value,
   input  logic [ctpf_pkg::LANE_W-1:0] a,
   input  logic [ctpf_pkg::LANE_W-1:0] b,
   input  logic [ctpf_pkg::LANE_W-1:0] c,
   output logic [ctpf_pkg::LANE_W-1:0] residual
);

   logic signed [10:0] sa, sb, sc, p, da, db, dc;
   logic signed [10:0] half, grad;
   logic [8:0] sum;
   logic [ctpf_pkg::LANE_W-1:0] paeth, med, hi, lo, gclamp, pred;

   always_comb begin
      sa = signed'({3'b000, a});
      sb = signed'({3'b000, b});
      sc = signed'({3'b000, c});
      p  = sa + sb - sc;
      da = (p - sa < 0) ? sa - p : p - sa;
      db = (p - sb < 0) ? sb - p : p - sb;
      dc = (p - sc < 0) ? sc - p : p - sc;
      if (da <= db && da <= dc) paeth = a;
      else if (db <= dc)        paeth = b;
      else                      paeth = c;

      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      if (c >= hi)      med = lo;
      else if (c <= lo) med = hi;
      else              med = a + b - c;

      half = (sb - sc) >>> 1;
      grad = sa + half;
      if (grad < 0)                                 gclamp = '0;
      else if (grad > signed'({3'b000, ctpf_pkg::LANE_MAX})) gclamp = ctpf_pkg::LANE_MAX;
      else                                          gclamp = grad[7:0];

      sum = {1'b0, a} + {1'b0, b};

      unique case (ctpf_pkg::pred_mode_type'(pred_mode))
         ctpf_pkg::MODE_LEFT:     pred = a;
         ctpf_pkg::MODE_UP:       pred = b;
         ctpf_pkg::MODE_AVERAGE:  pred = sum[8:1];
         ctpf_pkg::MODE_PAETH:    pred = paeth;
         ctpf_pkg::MODE_MED:      pred = med;
         ctpf_pkg::MODE_GRADIENT: pred = gclamp;
         default:                 pred = '0;
      endcase

      residual = en ? value - pred : '0;
   end

endmodule

// ===== sv/ctpf_line_store.sv =====
// Line store of the previous transformed row, with write-to-read bypass.
module ctpf_line_store (
   input  logic                       clock,
   input  ctpf_pkg::ls_wr_type        wr,
   input  ctpf_pkg::ls_rd_type        rd,
   output logic [ctpf_pkg::PIX_W-1:0] rd_data
);

   logic [ctpf_pkg::PIX_W-1:0] mem [ctpf_pkg::MAX_WIDTH];
   logic [ctpf_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && wr.addr == rd.addr) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/colour_transform_predict_filter_unit.sv =====
// Top level of the colour transform and predict filter: stages, counters, lanes, merge.
//
//   channel | ports              | direction | carries
//   req     | req_valid/ready    | in        | one pixel, eight byte lanes
//   rsp     | rsp_valid/ready    | out       | eight residuals, row_end, image_end
//   csr     | csr_valid/ready    | in        | register index and write data
//
// One pixel per cycle unless rsp stalls; held in stage one, then in the result register.
// Stage one transforms colour and reads the line store; stage two predicts in
// eight lanes and writes the line store, one read and one write port per cycle.
// Synchronous reset clears counters, valids and CSRs; the line store is not cleared.
// A stalled result holds its register; the input stage still takes one more pixel.
module colour_transform_predict_filter_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ctpf_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ctpf_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ctpf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ctpf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int L = ctpf_pkg::MAX_LANES;
   localparam int W = ctpf_pkg::LANE_W;

   logic [2:0]                      pred_mode_ff;
   logic [1:0]                      colour_mode_ff;
   logic [ctpf_pkg::WIDTH_W-1:0]    width_ff;
   logic [ctpf_pkg::HEIGHT_W-1:0]   height_ff;
   logic [ctpf_pkg::LANES_W-1:0]    lanes_ff;

   logic [ctpf_pkg::COL_W-1:0]      col_ff, col_in, col_eff, w_m1;
   logic [ctpf_pkg::HEIGHT_W-1:0]   row_ff, row_in, h_m1;
   logic [ctpf_pkg::WIDTH_W-1:0]    w_eff;
   logic [ctpf_pkg::LANES_W-1:0]    n_eff;
   logic                            row_end, img_end;

   logic                            req_fire, advance;
   logic [W-1:0]                    in_byte [L];
   logic [W-1:0]                    pix_in  [L];
   logic [W-1:0]                    c0, c1, c2;
   logic [L-1:0]                    lane_en;

   logic                            a_valid_ff;
   logic [ctpf_pkg::PIX_W-1:0]      a_pix_ff;
   logic [L-1:0]                    a_en_ff;
   logic [ctpf_pkg::COL_W-1:0]      a_col_ff;
   logic                            a_col_nz_ff, a_row_nz_ff, a_row_end_ff, a_img_end_ff;

   logic [ctpf_pkg::PIX_W-1:0]      left_ff, above_left_ff;
   logic [ctpf_pkg::PIX_W-1:0]      ls_data, above, left_px, upleft_px;
   logic [W-1:0]                    res [L];

   logic                            rsp_valid_ff;
   ctpf_pkg::rsp_payload_type       rsp_data_ff;

   ctpf_pkg::ls_wr_type             ls_wr;
   ctpf_pkg::ls_rd_type             ls_rd;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_mode_ff   <= 3'd0;
         colour_mode_ff <= 2'd0;
         width_ff       <= ctpf_pkg::WIDTH_W'(1);
         height_ff      <= ctpf_pkg::HEIGHT_W'(1);
         lanes_ff       <= ctpf_pkg::LANES_W'(3);
      end else if (csr_valid && csr_ready) begin
         unique case (ctpf_pkg::csr_index_type'(csr_index))
            ctpf_pkg::CSR_PREDICTOR_MODE:  pred_mode_ff   <= csr_wdata[2:0];
            ctpf_pkg::CSR_COLOUR_MODE:     colour_mode_ff <= csr_wdata[1:0];
            ctpf_pkg::CSR_IMAGE_WIDTH:     width_ff       <= csr_wdata[ctpf_pkg::WIDTH_W-1:0];
            ctpf_pkg::CSR_IMAGE_HEIGHT:    height_ff      <= csr_wdata[ctpf_pkg::HEIGHT_W-1:0];
            ctpf_pkg::CSR_LANES_PER_PIXEL: lanes_ff       <= csr_wdata[ctpf_pkg::LANES_W-1:0];
            default: ;
         endcase
      end
   end

   // position and limits
   always_comb begin
      priority if (width_ff == '0)
         w_eff = ctpf_pkg::WIDTH_W'(1);
      else if (width_ff > ctpf_pkg::WIDTH_W'(ctpf_pkg::MAX_WIDTH))
         w_eff = ctpf_pkg::WIDTH_W'(ctpf_pkg::MAX_WIDTH);
      else
         w_eff = width_ff;
      priority if (lanes_ff == '0)
         n_eff = ctpf_pkg::LANES_W'(1);
      else if (lanes_ff > ctpf_pkg::LANES_W'(ctpf_pkg::MAX_LANES))
         n_eff = ctpf_pkg::LANES_W'(ctpf_pkg::MAX_LANES);
      else
         n_eff = lanes_ff;
      w_m1    = ctpf_pkg::COL_W'(w_eff - ctpf_pkg::WIDTH_W'(1));
      h_m1    = (height_ff == '0) ? '0 : height_ff - ctpf_pkg::HEIGHT_W'(1);
      col_eff = (col_ff > w_m1) ? w_m1 : col_ff;
      row_end = (col_ff >= w_m1);
      img_end = row_end && (row_ff >= h_m1);
      if (row_end) begin
         col_in = '0;
         row_in = img_end ? '0 : row_ff + ctpf_pkg::HEIGHT_W'(1);
      end else begin
         col_in = col_ff + ctpf_pkg::COL_W'(1);
         row_in = row_ff;
      end
   end

   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage one: lane masking and colour transform
   assign in_byte[0] = req_data.byte_0;
   assign in_byte[1] = req_data.byte_1;
   assign in_byte[2] = req_data.byte_2;
   assign in_byte[3] = req_data.byte_3;
   assign in_byte[4] = req_data.byte_4;
   assign in_byte[5] = req_data.byte_5;
   assign in_byte[6] = req_data.byte_6;
   assign in_byte[7] = req_data.byte_7;

   for (genvar i = 0; i < L; i++) begin : g_mask
      assign lane_en[i] = (ctpf_pkg::LANES_W'(i) < n_eff);
   end

   ctpf_colour u_colour (
      .colour_mode (colour_mode_ff),
      .active      (n_eff >= ctpf_pkg::LANES_W'(3)),
      .r_in        (in_byte[0]),
      .g_in        (in_byte[1]),
      .b_in        (in_byte[2]),
      .c0_out      (c0),
      .c1_out      (c1),
      .c2_out      (c2)
   );

   always_comb begin
      for (int i = 0; i < L; i++) begin
         pix_in[i] = lane_en[i] ? in_byte[i] : '0;
      end
      if (n_eff >= ctpf_pkg::LANES_W'(3)) begin
         pix_in[0] = c0;
         pix_in[1] = c1;
         pix_in[2] = c2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_fire) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < L; i++) begin
            a_pix_ff[i*W +: W] <= pix_in[i];
         end
         a_en_ff      <= lane_en;
         a_col_ff     <= col_eff;
         a_col_nz_ff  <= (col_eff != '0);
         a_row_nz_ff  <= (row_ff != '0);
         a_row_end_ff <= row_end;
         a_img_end_ff <= img_end;
      end
   end

   assign ls_rd.en   = req_fire;
   assign ls_rd.addr = col_eff;
   assign ls_wr.en   = advance;
   assign ls_wr.addr = a_col_ff;
   assign ls_wr.data = a_pix_ff;

   ctpf_line_store u_line_store (
      .clock   (clock),
      .wr      (ls_wr),
      .rd      (ls_rd),
      .rd_data (ls_data)
   );

   // stage two: neighbours, lanes, merge
   assign above     = a_row_nz_ff ? ls_data : '0;
   assign left_px   = a_col_nz_ff ? left_ff : '0;
   assign upleft_px = (a_col_nz_ff && a_row_nz_ff) ? above_left_ff : '0;

   for (genvar i = 0; i < L; i++) begin : g_lane
      ctpf_lane u_lane (
         .pred_mode (pred_mode_ff),
         .en        (a_en_ff[i]),
         .value     (a_pix_ff[i*W +: W]),
         .a         (left_px[i*W +: W]),
         .b         (above[i*W +: W]),
         .c         (upleft_px[i*W +: W]),
         .residual  (res[i])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff       <= a_pix_ff;
         above_left_ff <= above;
         rsp_data_ff.residual_0 <= res[0];
         rsp_data_ff.residual_1 <= res[1];
         rsp_data_ff.residual_2 <= res[2];
         rsp_data_ff.residual_3 <= res[3];
         rsp_data_ff.residual_4 <= res[4];
         rsp_data_ff.residual_5 <= res[5];
         rsp_data_ff.residual_6 <= res[6];
         rsp_data_ff.residual_7 <= res[7];
         rsp_data_ff.row_end    <= a_row_end_ff;
         rsp_data_ff.image_end  <= a_img_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_img_implies_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.image_end || rsp_data_ff.row_end))
      else $error("image_end without row_end");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !advance) |=> a_valid_ff)
      else $error("stage one item dropped while stalled");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !a_valid_ff |-> req_ready)
      else $error("input blocked with empty stage");

   a_image_wrap : assert property (@(posedge clock) disable iff (reset)
      (req_fire && img_end) |=> (row_ff == '0 && col_ff == '0))
      else $error("position not cleared after image end");

   a_unused_lane : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && n_eff < ctpf_pkg::LANES_W'(ctpf_pkg::MAX_LANES))
      |-> (rsp_data_ff.residual_7 == '0))
      else $error("unused lane carries a residual");

endmodule
